FILE: sv/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam int unsigned KwChars = 16;

  localparam logic [4:0] KindNum    = 5'd0;
  localparam logic [4:0] KindStr    = 5'd1;
  localparam logic [4:0] KindIdent  = 5'd2;
  localparam logic [4:0] KindKw     = 5'd3;
  localparam logic [4:0] KindDotDot = 5'd4;
  localparam logic [4:0] KindArrow  = 5'd5;
  localparam logic [4:0] KindSym0   = 5'd6;
  localparam logic [4:0] KindMinus  = 5'd17;
  localparam logic [4:0] KindEnd    = 5'd21;
  localparam logic [4:0] KindBad    = 5'd22;
  localparam logic [4:0] KindUnterm = 5'd23;

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeComment = 3'd1;
  localparam logic [2:0] ModeNum     = 3'd2;
  localparam logic [2:0] ModeIdent   = 3'd3;
  localparam logic [2:0] ModeStr     = 3'd4;
  localparam logic [2:0] ModeDot     = 3'd5;
  localparam logic [2:0] ModeMinus   = 3'd6;

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  kw;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } bundle_t;

  function automatic logic [4:0] kw_len(input int unsigned k);
    case (k)
      0, 14: return 5'd3;
      2, 3, 4: return 5'd4;
      8, 10, 16: return 5'd5;
      7, 9: return 5'd7;
      17: return 5'd9;
      18: return 5'd11;
      1, 5, 6, 11, 12, 13, 15, 19: return 5'd6;
      default: return 5'd0;
    endcase
  endfunction

  // keyword text is right aligned, first character in the highest used byte
  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
    logic [KwChars*8-1:0] w;
    int unsigned          l;
    case (k)
      0: w = "Num";
      1: w = "String";
      2: w = "List";
      3: w = "Pair";
      4: w = "Vec3";
      5: w = "Quater";
      6: w = "Random";
      7: w = "Lambert";
      8: w = "Metal";
      9: w = "Dielect";
      10: w = "Light";
      11: w = "XYRect";
      12: w = "XZRect";
      13: w = "YZRect";
      14: w = "Box";
      15: w = "Sphere";
      16: w = "Heart";
      17: w = "Translate";
      18: w = "ConstMedium";
      19: w = "Camera";
      default: w = '0;
    endcase
    l = 32'(kw_len(k));
    if (i < l) begin
      return w[8*(l-1-i) +: 8];
    end
    return 8'd0;
  endfunction

  function automatic logic [4:0] sym_index(input logic [7:0] c);
    case (c)
      "(": return 5'd0;
      ")": return 5'd1;
      "[": return 5'd2;
      "]": return 5'd3;
      "{": return 5'd4;
      "}": return 5'd5;
      ":": return 5'd6;
      ",": return 5'd7;
      "=": return 5'd8;
      "|": return 5'd9;
      "+": return 5'd10;
      "-": return 5'd11;
      "*": return 5'd12;
      "/": return 5'd13;
      "%": return 5'd14;
      default: return 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/stt_if.sv
`default_nettype none
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;
  modport source (output valid, text_byte, final_byte, input ready);
  modport sink (input valid, text_byte, final_byte, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [4:0]  keyword_index;
  logic [15:0] lexeme_start;
  logic [15:0] lexeme_length;
  logic        end_of_run;
  modport source (output valid, token_kind, keyword_index, lexeme_start, lexeme_length,
    end_of_run, input ready);
  modport sink (input valid, token_kind, keyword_index, lexeme_start, lexeme_length,
    end_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/stt_front.sv
`default_nettype none
module stt_front
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned KEYWORD_COUNT = 20,
  parameter int unsigned MAX_KEYWORD_LENGTH = 11
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       final_i,
  output logic            push_o,
  output bundle_t         bundle_o,
  input  wire logic       full_i
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [2:0]               mode_q, mode_d;
  logic                     single_q, single_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, start_q, start_d, len_q, len_d;
  logic [KEYWORD_COUNT-1:0] cand_q, cand_d;
  logic                     err_q, err_d;

  logic   fire;
  token_t tk [3];
  logic [1:0] n;

  assign ready_o = !full_i;
  assign fire = valid_i && ready_o;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clip(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_" || c == "$";
  endfunction

  function automatic logic [KEYWORD_COUNT-1:0] kw_keep(input logic [7:0] c,
                                                       input logic [POSITION_BITS-1:0] idx);
    logic [KEYWORD_COUNT-1:0] keep;
    keep = '0;
    if (32'(idx) < MAX_KEYWORD_LENGTH && 32'(idx) < KwChars) begin
      for (int unsigned k = 0; k < KEYWORD_COUNT; k++) begin
        keep[k] = (kw_char(k, 32'(idx)) == c);
      end
    end
    return keep;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [POSITION_BITS-1:0] p;
    logic do_begin;
    logic [4:0] si;
    logic [4:0] kwi;
    logic fin_ident, flush_ident;
    c = byte_i;
    p = pos_q;
    mode_d = mode_q;
    single_d = single_q;
    pos_d = pos_q;
    start_d = start_q;
    len_d = len_q;
    cand_d = cand_q;
    err_d = err_q;
    n = 2'd0;
    do_begin = 1'b0;
    fin_ident = 1'b0;
    flush_ident = 1'b0;
    si = sym_index(c);
    kwi = 5'd0;
    for (int i = 0; i < 3; i++) begin
      tk[i] = '0;
    end
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (cand_q[k] && 32'(kw_len(k)) == 32'(len_q) && 32'(len_q) <= MAX_KEYWORD_LENGTH) begin
        kwi = 5'(k + 1);
      end
    end

    if (!err_q) begin
      case (mode_q)
        ModeComment: begin
          if (c == 8'h0A) begin
            mode_d = ModeIdle;
          end
        end
        ModeStr: begin
          if (c == (single_q ? 8'h27 : 8'h22)) begin
            tk[0] = '{KindStr, 5'd0, clip(start_q), clip(len_q), 1'b0};
            n = 2'd1;
            mode_d = ModeIdle;
          end else begin
            len_d = sat_inc(len_q);
          end
        end
        ModeDot, ModeNum: begin
          if (mode_q == ModeDot && c == ".") begin
            tk[0] = '{KindDotDot, 5'd0, clip(start_q), 16'd2, 1'b0};
            n = 2'd1;
            mode_d = ModeIdle;
          end else if (is_digit(c) || c == "." || c == "-") begin
            mode_d = ModeNum;
            len_d = sat_inc(len_q);
          end else begin
            tk[0] = '{KindNum, 5'd0, clip(start_q), clip(len_q), 1'b0};
            n = 2'd1;
            do_begin = 1'b1;
          end
        end
        ModeIdent: begin
          if (is_ident(c)) begin
            cand_d = cand_q & kw_keep(c, len_q);
            len_d = sat_inc(len_q);
          end else begin
            fin_ident = 1'b1;
            n = 2'd1;
            do_begin = 1'b1;
          end
        end
        ModeMinus: begin
          if (c == ">") begin
            tk[0] = '{KindArrow, 5'd0, clip(start_q), 16'd2, 1'b0};
            n = 2'd1;
            mode_d = ModeIdle;
          end else begin
            tk[0] = '{KindMinus, 5'd0, clip(start_q), 16'd1, 1'b0};
            n = 2'd1;
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
      if (fin_ident) begin
        tk[0] = (kwi != 5'd0) ? '{KindKw, kwi, clip(start_q), clip(len_q), 1'b0}
                              : '{KindIdent, 5'd0, clip(start_q), clip(len_q), 1'b0};
      end
      if (do_begin) begin
        mode_d = ModeIdle;
        start_d = p;
        len_d = POSITION_BITS'(1);
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          mode_d = ModeIdle;
        end else if (c == "#") begin
          mode_d = ModeComment;
        end else if (c == ".") begin
          mode_d = ModeDot;
        end else if (c == "-") begin
          mode_d = ModeMinus;
        end else if (is_digit(c)) begin
          mode_d = ModeNum;
        end else if (c == 8'h22 || c == 8'h27) begin
          mode_d = ModeStr;
          single_d = (c == 8'h27);
          start_d = sat_inc(p);
          len_d = '0;
        end else if (is_alpha(c) || c == "_" || c == "$") begin
          mode_d = ModeIdent;
          cand_d = kw_keep(c, '0);
        end else if (si != 5'd31) begin
          tk[n] = '{5'(KindSym0 + si), 5'd0, clip(p), 16'd1, 1'b0};
          n = n + 2'd1;
        end else begin
          tk[n] = '{KindBad, 5'd0, clip(p), 16'd1, 1'b0};
          n = n + 2'd1;
          err_d = 1'b1;
        end
      end
    end

    if (final_i) begin
      if (!err_q && !err_d) begin
        case (mode_d)
          ModeNum: begin
            tk[n] = '{KindNum, 5'd0, clip(start_d), clip(len_d), 1'b0};
            n = n + 2'd1;
          end
          ModeDot: begin
            tk[n] = '{KindNum, 5'd0, clip(start_d), 16'd1, 1'b0};
            n = n + 2'd1;
          end
          ModeMinus: begin
            tk[n] = '{KindMinus, 5'd0, clip(start_d), 16'd1, 1'b0};
            n = n + 2'd1;
          end
          ModeIdent: flush_ident = 1'b1;
          ModeStr: begin
            tk[n] = '{KindUnterm, 5'd0, clip(start_d), clip(len_d), 1'b0};
            n = n + 2'd1;
          end
          default: ;
        endcase
      end
      if (flush_ident) begin
        kwi = 5'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
          if (cand_d[k] && 32'(kw_len(k)) == 32'(len_d)
              && 32'(len_d) <= MAX_KEYWORD_LENGTH) begin
            kwi = 5'(k + 1);
          end
        end
        tk[n] = (kwi != 5'd0) ? '{KindKw, kwi, clip(start_d), clip(len_d), 1'b0}
                              : '{KindIdent, 5'd0, clip(start_d), clip(len_d), 1'b0};
        n = n + 2'd1;
      end
      tk[n] = '{KindEnd, 5'd0, clip(sat_inc(p)), 16'd0, 1'b0};
      n = n + 2'd1;
      mode_d = ModeIdle;
      single_d = 1'b0;
      pos_d = '0;
      start_d = '0;
      len_d = '0;
      cand_d = '0;
      err_d = 1'b0;
    end else begin
      pos_d = sat_inc(p);
    end
    if (n != 2'd0) begin
      tk[n - 2'd1].last = 1'b1;
    end
  end

  assign push_o = fire && (n != 2'd0);
  assign bundle_o = '{n, tk[0], tk[1], tk[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      single_q <= 1'b0;
      pos_q <= '0;
      start_q <= '0;
      len_q <= '0;
      cand_q <= '0;
      err_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d;
      single_q <= single_d;
      pos_q <= pos_d;
      start_q <= start_d;
      len_q <= len_d;
      cand_q <= cand_d;
      err_q <= err_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/stt_queue.sv
`default_nettype none
module stt_queue
  import stt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t bundle_i,
  output logic         full_o,
  output logic         valid_o,
  output bundle_t      bundle_o,
  input  wire logic    pop_i
);

  bundle_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign bundle_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: sv/stt_back.sv
`default_nettype none
module stt_back
  import stt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire bundle_t bundle_i,
  output logic         pop_o,
  output logic         valid_o,
  output token_t       token_o,
  input  wire logic    ready_i
);

  logic [1:0] idx_q;
  logic       take;

  assign valid_o = valid_i;
  assign take = valid_i && ready_i;
  assign pop_o = take && (idx_q + 2'd1 == bundle_i.count);

  always_comb begin
    case (idx_q)
      2'd0: token_o = bundle_i.t0;
      2'd1: token_o = bundle_i.t1;
      default: token_o = bundle_i.t2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= pop_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: sv/scene_text_tokenizer.sv
// scene text tokenizer: streaming lexical scanner
// in_i carries one source byte per transaction, with final_byte on the last
// byte of a text; out_o carries one token per transaction
// the front scanner accepts one byte per cycle while the queue is not full
// and writes the 0 to 3 tokens made for it into a two-entry queue as the
// byte is taken; the back end hands them out one per cycle while out_o is
// ready, so a byte that makes n tokens holds the output until all are taken
// throughput: one byte per cycle while tokens are drained as fast as made
// a stalled receiver fills the queue, and then in_i.ready drops
// end_of_run marks the last token of a byte; after the final byte an end
// token follows and scanning restarts at offset 0
// reset clears the scanner, the queue and the output position
`default_nettype none
module scene_text_tokenizer
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned KEYWORD_COUNT = 20,
  parameter int unsigned MAX_KEYWORD_LENGTH = 11
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  stt_in_if.sink   in_i,
  stt_out_if.source out_o
);

  logic    push, full, qvalid, pop;
  bundle_t fb, qb;
  token_t  tk;

  stt_front #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_COUNT(KEYWORD_COUNT),
    .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)
  ) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .ready_o(in_i.ready),
    .byte_i(in_i.text_byte), .final_i(in_i.final_byte),
    .push_o(push), .bundle_o(fb), .full_i(full)
  );

  stt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .bundle_i(fb), .full_o(full),
    .valid_o(qvalid), .bundle_o(qb), .pop_i(pop)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .valid_i(qvalid), .bundle_i(qb), .pop_o(pop),
    .valid_o(out_o.valid), .token_o(tk), .ready_i(out_o.ready)
  );

  assign out_o.token_kind = tk.kind;
  assign out_o.keyword_index = tk.kw;
  assign out_o.lexeme_start = tk.start;
  assign out_o.lexeme_length = tk.len;
  assign out_o.end_of_run = tk.last;

endmodule
`default_nettype wire

FILE: dv/stt_tb_if.sv
`timescale 1ns / 1ps
// interfaces come from the rtl; this file only declares the stimulus row type
package stt_tb_pkg;
  import stt_pkg::*;

  typedef struct {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       typed;
    token_t     token;
  } stim_row_t;
endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import stt_pkg::*;
  import stt_tb_pkg::*;

  localparam int unsigned PosMax = 16'hFFFF;
  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [2:0] {
    ScanIdle, ScanComment, ScanNum, ScanIdent, ScanStr, ScanDot, ScanMinus
  } scan_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  stt_in_if in_if ();
  stt_out_if out_if ();

  scene_text_tokenizer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if.sink),
    .out_o(out_if.source)
  );

  // scanner state mirror
  scan_e       lex_mode;
  logic        lex_single_quote;
  int unsigned lex_pos;
  int unsigned lex_start;
  int unsigned lex_len;
  logic [31:0] lex_kw_mask;
  logic        lex_error;

  token_t token_queue[$];
  token_t step_tokens[$];
  int     errors = 0;
  int     recv_stall_pct = 0;

  string kw_names[20] = '{"Num", "String", "List", "Pair", "Vec3", "Quater", "Random",
    "Lambert", "Metal", "Dielect", "Light", "XYRect", "XZRect", "YZRect", "Box",
    "Sphere", "Heart", "Translate", "ConstMedium", "Camera"};
  string sym_chars = "()[]{}:,=|+-*/%";

  function automatic int unsigned sat_inc(int unsigned v);
    return v >= PosMax ? PosMax : v + 1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_ident_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_" || c == "$";
  endfunction

  function automatic void push_token(logic [4:0] kind, logic [4:0] kw, int unsigned start,
                                     int unsigned len);
    token_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = kind;
    t.kw = kw;
    t.start = start > PosMax ? 16'hFFFF : start[15:0];
    t.len = len > PosMax ? 16'hFFFF : len[15:0];
    t.last = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void narrow_keywords(logic [7:0] c, int unsigned idx);
    logic [31:0] keep;
    keep = '0;
    if (idx >= 11) begin
      lex_kw_mask = '0;
      return;
    end
    for (int k = 0; k < 20; k++) begin
      if (idx < kw_names[k].len() && kw_names[k][idx] == c) keep[k] = 1'b1;
    end
    lex_kw_mask &= keep;
  endfunction

  function automatic void close_ident();
    for (int k = 0; k < 20; k++) begin
      if (lex_kw_mask[k] && kw_names[k].len() == lex_len && lex_len <= 11) begin
        push_token(KindKw, 5'(k + 1), lex_start, lex_len);
        return;
      end
    end
    push_token(KindIdent, 5'd0, lex_start, lex_len);
  endfunction

  function automatic void open_lexeme(logic [7:0] c, int unsigned p);
    lex_mode = ScanIdle;
    lex_start = p;
    lex_len = 1;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == "#") lex_mode = ScanComment;
    else if (c == ".") lex_mode = ScanDot;
    else if (c == "-") lex_mode = ScanMinus;
    else if (is_digit(c)) lex_mode = ScanNum;
    else if (c == "\"" || c == "'") begin
      lex_mode = ScanStr;
      lex_single_quote = (c == "'");
      lex_start = sat_inc(p);
      lex_len = 0;
    end else if (is_alpha(c) || c == "_" || c == "$") begin
      lex_mode = ScanIdent;
      lex_kw_mask = '1;
      narrow_keywords(c, 0);
    end else begin
      for (int i = 0; i < 15; i++) begin
        if (sym_chars[i] == c) begin
          push_token(KindSym0 + 5'(i), 5'd0, p, 1);
          return;
        end
      end
      push_token(KindBad, 5'd0, p, 1);
      lex_error = 1'b1;
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, int unsigned p);
    case (lex_mode)
      ScanComment: if (c == 8'h0A) lex_mode = ScanIdle;
      ScanStr: begin
        if (c == (lex_single_quote ? 8'h27 : 8'h22)) begin
          push_token(KindStr, 5'd0, lex_start, lex_len);
          lex_mode = ScanIdle;
        end else lex_len = sat_inc(lex_len);
      end
      ScanDot, ScanNum: begin
        if (lex_mode == ScanDot && c == ".") begin
          push_token(KindDotDot, 5'd0, lex_start, 2);
          lex_mode = ScanIdle;
        end else begin
          lex_mode = ScanNum;
          if (is_digit(c) || c == "." || c == "-") lex_len = sat_inc(lex_len);
          else begin
            push_token(KindNum, 5'd0, lex_start, lex_len);
            open_lexeme(c, p);
          end
        end
      end
      ScanIdent: begin
        if (is_ident_char(c)) begin
          narrow_keywords(c, lex_len);
          lex_len = sat_inc(lex_len);
        end else begin
          close_ident();
          open_lexeme(c, p);
        end
      end
      ScanMinus: begin
        if (c == ">") begin
          push_token(KindArrow, 5'd0, lex_start, 2);
          lex_mode = ScanIdle;
        end else begin
          push_token(KindMinus, 5'd0, lex_start, 1);
          open_lexeme(c, p);
        end
      end
      default: open_lexeme(c, p);
    endcase
  endfunction

  function automatic void clear_scanner();
    lex_mode = ScanIdle;
    lex_single_quote = 1'b0;
    lex_pos = 0;
    lex_start = 0;
    lex_len = 0;
    lex_kw_mask = '0;
    lex_error = 1'b0;
  endfunction

  // tokens caused by one byte land in step_tokens
  function automatic void tokenize_byte(logic [7:0] c, logic fin);
    int unsigned p;
    p = lex_pos;
    step_tokens.delete();
    if (!lex_error) scan_char(c, p);
    if (fin) begin
      if (!lex_error) begin
        case (lex_mode)
          ScanNum: push_token(KindNum, 5'd0, lex_start, lex_len);
          ScanDot: push_token(KindNum, 5'd0, lex_start, 1);
          ScanMinus: push_token(KindMinus, 5'd0, lex_start, 1);
          ScanIdent: close_ident();
          ScanStr: push_token(KindUnterm, 5'd0, lex_start, lex_len);
          default: ;
        endcase
      end
      push_token(KindEnd, 5'd0, sat_inc(p), 0);
      clear_scanner();
    end else lex_pos = sat_inc(p);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  // output checker
  always @(posedge clk_i) begin
    token_t got;
    token_t exp_tok;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind = out_if.token_kind;
      got.kw = out_if.keyword_index;
      got.start = out_if.lexeme_start;
      got.len = out_if.lexeme_length;
      got.last = out_if.end_of_run;
      if (token_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, actual %p", $time, got);
      end else begin
        exp_tok = token_queue.pop_front();
        if (got !== exp_tok) begin
          errors++;
          $display("%0t: token mismatch, expected %p, actual %p", $time, exp_tok, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one byte; predicted tokens are queued at acceptance
  task automatic send_byte(logic [7:0] c, logic fin, int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= c;
    in_if.final_byte <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    tokenize_byte(c, fin);
    foreach (step_tokens[i]) token_queue.insert(token_queue.size(), step_tokens[i]);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, int idle_pct);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1, idle_pct);
  endtask

  function automatic string random_lexeme();
    int sel;
    string s;
    sel = $urandom_range(11);
    case (sel)
      0: s = kw_names[$urandom_range(19)];
      1: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99));
      2: s = "\"ab c\"";
      3: s = "'q\"x'";
      4: s = "..";
      5: s = "->";
      6: s = string'(sym_chars[$urandom_range(14)]);
      7: s = "# note\n";
      8: s = "_v$9";
      9: s = "-";
      10: s = ".";
      default: s = {kw_names[$urandom_range(19)], "x"};
    endcase
    return s;
  endfunction

  task automatic run_phase(int n_items, int idle_pct);
    int n;
    string s;
    n = 0;
    while (n < n_items) begin
      s = "";
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(255)))};
      end else begin
        repeat ($urandom_range(1, 6)) begin
          s = {s, random_lexeme()};
          if ($urandom_range(3) != 0) s = {s, " "};
        end
      end
      send_text(s, idle_pct);
      n += s.len();
    end
  endtask

  stim_row_t rows[$];

  function automatic void add_row(logic [7:0] c, logic fin, logic typed = 1'b0,
                                  logic [4:0] kind = 0, logic [15:0] start = 0,
                                  logic [15:0] len = 0);
    stim_row_t r;
    r.text_byte = c;
    r.final_byte = fin;
    r.typed = typed;
    r.token = '{kind: kind, kw: 5'd0, start: start, len: len, last: 1'b1};
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    int base;
    in_if.valid = 1'b0;
    in_if.text_byte = '0;
    in_if.final_byte = 1'b0;
    out_if.ready = 1'b0;
    clear_scanner();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_row(8'h00, 1'b0, 1'b1, KindBad, 0, 1);
    add_row("x", 1'b1, 1'b1, KindEnd, 2, 0);
    add_row(8'hFF, 1'b1);
    add_row(8'h80, 1'b1);
    add_row("\"", 1'b0);
    add_row("a", 1'b1);
    add_row("-", 1'b1);
    add_row(".", 1'b1);
    add_row("7", 1'b0);
    add_row("-", 1'b0);
    add_row(">", 1'b0);
    add_row("!", 1'b1);
    foreach (rows[i]) begin
      send_byte(rows[i].text_byte, rows[i].final_byte, 0);
      if (rows[i].typed && step_tokens[step_tokens.size() - 1] !== rows[i].token) begin
        errors++;
        $display("%0t: table row %0d, expected %p, actual %p", $time, i, rows[i].token,
                 step_tokens[step_tokens.size() - 1]);
      end
    end
    send_text("Vec3 ConstMedium Translatex(..){}:,=|+*/%[]$_ 'z", 0);

    base = 60;
    recv_stall_pct = 0;
    run_phase(base, 0);
    run_phase(base, 50);
    recv_stall_pct = 50;
    run_phase(base, 0);
    recv_stall_pct = 36;
    run_phase(base, 36);
    recv_stall_pct = 0;
    in_if.valid <= 1'b0;

    while (token_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: sim.f
sv/stt_pkg.sv
sv/stt_if.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/scene_text_tokenizer.sv
dv/stt_tb_if.sv
dv/tb_top.sv
